/* hdl/gppm_pkg.sv */
// ----------------------------------------------------------------------------
// gppm_pkg
// shared types and constants of the greedy peak pair matcher
// ----------------------------------------------------------------------------
package gppm_pkg;

    localparam int MaxPeaks  = 32;
    localparam int IdxBits   = $clog2(MaxPeaks);
    localparam int CntBits   = $clog2(MaxPeaks + 1);
    localparam int CoordBits = 16;
    localparam int DistBits  = 49;
    localparam int QueueDepth = 2;
    localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};

    typedef enum logic [1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_RUN         = 2'd2,
        OP_NONE        = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_WEIGHT_C  = 2'd0,
        REG_WEIGHT_H  = 2'd1,
        REG_THRESHOLD = 2'd2
    } reg_index_t;

    // command word handed from front to back
    typedef struct packed {
        opcode_t              op;
        logic [CoordBits-1:0] c;
        logic [CoordBits-1:0] h;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_DIST,
        ST_SUM,
        ST_DECIDE,
        ST_CLOSE
    } back_state_t;

endpackage

/* hdl/gppm_front.sv */
// ----------------------------------------------------------------------------
// gppm_front
// accepts input words, drops unknown opcodes, queues commands for the back end
// ----------------------------------------------------------------------------
module gppm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic [15:0]                 coord_c,
    input  logic [15:0]                 coord_h,
    output logic                        cmd_valid,
    output gppm_pkg::cmd_t              cmd,
    input  logic                        cmd_take
);

    localparam int PtrBits = $clog2(gppm_pkg::QueueDepth);

    gppm_pkg::cmd_t        queue_reg [gppm_pkg::QueueDepth];
    logic [PtrBits-1:0]    wr_ptr_reg;
    logic [PtrBits-1:0]    rd_ptr_reg;
    logic [PtrBits:0]      fill_reg;
    logic                  push;
    logic                  pop;
    gppm_pkg::cmd_t        word;

    assign in_stall  = (fill_reg == (PtrBits+1)'(gppm_pkg::QueueDepth));
    assign word.op   = gppm_pkg::opcode_t'(opcode);
    assign word.c    = coord_c;
    assign word.h    = coord_h;
    // unknown opcode is swallowed here
    assign push      = in_valid && !in_stall && (word.op != gppm_pkg::OP_NONE);
    assign pop       = cmd_take && cmd_valid;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
        end
    end

endmodule

/* hdl/gppm_back.sv */
// ----------------------------------------------------------------------------
// gppm_back
// stores points and walks all pairs per greedy round, emits matches
// ----------------------------------------------------------------------------
module gppm_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cmd_valid,
    input  gppm_pkg::cmd_t                         cmd,
    output logic                                   cmd_take,
    input  logic [15:0]                            carbon_wt,
    input  logic [15:0]                            proton_wt,
    input  logic [gppm_pkg::DistBits-1:0]          threshold_sq,
    output logic                                   res_valid,
    input  logic                                   res_stall,
    output logic                                   res_matched,
    output logic [gppm_pkg::IdxBits-1:0]           res_first,
    output logic [gppm_pkg::IdxBits-1:0]           res_second,
    output logic [gppm_pkg::DistBits-1:0]          res_dist,
    output logic [gppm_pkg::CntBits-1:0]           res_count,
    output logic                                   res_overflow,
    output logic                                   res_last
);

    localparam int IB = gppm_pkg::IdxBits;
    localparam int CB = gppm_pkg::CntBits;
    localparam int WB = gppm_pkg::CoordBits;
    localparam int DB = gppm_pkg::DistBits;

    logic [2*WB-1:0] first_mem  [gppm_pkg::MaxPeaks];
    logic [2*WB-1:0] second_mem [gppm_pkg::MaxPeaks];

    gppm_pkg::back_state_t state_reg, state_next;
    logic [CB-1:0]  first_cnt_reg, first_cnt_next;
    logic [CB-1:0]  second_cnt_reg, second_cnt_next;
    logic [gppm_pkg::MaxPeaks-1:0] first_used_reg, first_used_next;
    logic [gppm_pkg::MaxPeaks-1:0] second_used_reg, second_used_next;
    logic           dropped_reg, dropped_next;
    logic [CB-1:0]  i_reg, i_next;
    logic [CB-1:0]  j_reg, j_next;
    logic           found_reg, found_next;
    logic [DB-1:0]  best_reg, best_next;
    logic [IB-1:0]  bi_reg, bi_next;
    logic [IB-1:0]  bj_reg, bj_next;
    logic [CB-1:0]  nmatch_reg, nmatch_next;
    logic           pend_reg, pend_next;

    // match held back until the next one shows whether it is the last
    logic [IB-1:0]  pf_reg, pf_next;
    logic [IB-1:0]  ps_reg, ps_next;
    logic [DB-1:0]  pd_reg, pd_next;

    // pipeline registers of the distance datapath
    logic [2*WB-1:0] fp_reg, sp_reg;
    logic [WB-1:0]   dc_reg, dh_reg;
    logic [2*WB-1:0] sqc_reg, sqh_reg;
    logic [2*WB+15:0] tc_reg, th_reg;

    // output register
    logic            ov_reg, ov_next;
    logic            om_reg, om_next;
    logic [IB-1:0]   of_reg, of_next;
    logic [IB-1:0]   os_reg, os_next;
    logic [DB-1:0]   od_reg, od_next;
    logic [CB-1:0]   oc_reg, oc_next;
    logic            oo_reg, oo_next;
    logic            ol_reg, ol_next;

    logic            out_free;
    logic [2*WB+16:0] sum;
    logic [DB-1:0]   dist_sat;
    logic            pair_ok;
    logic [2:0]      step_reg, step_next;

    assign res_valid    = ov_reg;
    assign res_matched  = om_reg;
    assign res_first    = of_reg;
    assign res_second   = os_reg;
    assign res_dist     = od_reg;
    assign res_count    = oc_reg;
    assign res_overflow = oo_reg;
    assign res_last     = ol_reg;
    assign out_free     = !ov_reg || !res_stall;

    assign sum  = {1'b0, tc_reg} + {1'b0, th_reg};
    assign dist_sat = (sum > (2*WB+17)'(gppm_pkg::DistMax)) ? gppm_pkg::DistMax : DB'(sum);

    assign pair_ok = !first_used_reg[i_reg[IB-1:0]] && !second_used_reg[j_reg[IB-1:0]];

    // point stores
    always_ff @(posedge clk)
    begin
        if (state_reg == gppm_pkg::ST_IDLE && cmd_valid && cmd_take)
        begin
            if (cmd.op == gppm_pkg::OP_LOAD_FIRST && first_cnt_reg < CB'(gppm_pkg::MaxPeaks))
            begin
                first_mem[first_cnt_reg[IB-1:0]] <= {cmd.c, cmd.h};
            end
            if (cmd.op == gppm_pkg::OP_LOAD_SECOND && second_cnt_reg < CB'(gppm_pkg::MaxPeaks))
            begin
                second_mem[second_cnt_reg[IB-1:0]] <= {cmd.c, cmd.h};
            end
        end
        fp_reg <= first_mem[i_reg[IB-1:0]];
        sp_reg <= second_mem[j_reg[IB-1:0]];
    end

    // distance datapath, one stage per step of the pair sequencer
    always_ff @(posedge clk)
    begin
        dc_reg  <= (fp_reg[2*WB-1:WB] > sp_reg[2*WB-1:WB]) ?
                   fp_reg[2*WB-1:WB] - sp_reg[2*WB-1:WB] : sp_reg[2*WB-1:WB] - fp_reg[2*WB-1:WB];
        dh_reg  <= (fp_reg[WB-1:0] > sp_reg[WB-1:0]) ?
                   fp_reg[WB-1:0] - sp_reg[WB-1:0] : sp_reg[WB-1:0] - fp_reg[WB-1:0];
        sqc_reg <= dc_reg * dc_reg;
        sqh_reg <= dh_reg * dh_reg;
        tc_reg  <= sqc_reg * carbon_wt;
        th_reg  <= sqh_reg * proton_wt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= gppm_pkg::ST_IDLE;
            first_cnt_reg   <= '0;
            second_cnt_reg  <= '0;
            first_used_reg  <= '0;
            second_used_reg <= '0;
            dropped_reg     <= 1'b0;
            i_reg           <= '0;
            j_reg           <= '0;
            found_reg       <= 1'b0;
            nmatch_reg      <= '0;
            pend_reg        <= 1'b0;
            ov_reg          <= 1'b0;
            step_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            first_cnt_reg   <= first_cnt_next;
            second_cnt_reg  <= second_cnt_next;
            first_used_reg  <= first_used_next;
            second_used_reg <= second_used_next;
            dropped_reg     <= dropped_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            found_reg       <= found_next;
            nmatch_reg      <= nmatch_next;
            pend_reg        <= pend_next;
            ov_reg          <= ov_next;
            step_reg        <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        bi_reg   <= bi_next;
        bj_reg   <= bj_next;
        pf_reg   <= pf_next;
        ps_reg   <= ps_next;
        pd_reg   <= pd_next;
        om_reg   <= om_next;
        of_reg   <= of_next;
        os_reg   <= os_next;
        od_reg   <= od_next;
        oc_reg   <= oc_next;
        oo_reg   <= oo_next;
        ol_reg   <= ol_next;
    end

    // sequencer: for each pair, read (PRE), then through the datapath (DIST, SUM)
    always_comb
    begin
        state_next       = state_reg;
        first_cnt_next   = first_cnt_reg;
        second_cnt_next  = second_cnt_reg;
        first_used_next  = first_used_reg;
        second_used_next = second_used_reg;
        dropped_next     = dropped_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        found_next       = found_reg;
        best_next        = best_reg;
        bi_next          = bi_reg;
        bj_next          = bj_reg;
        nmatch_next      = nmatch_reg;
        pend_next        = pend_reg;
        pf_next          = pf_reg;
        ps_next          = ps_reg;
        pd_next          = pd_reg;
        step_next        = step_reg;
        cmd_take         = 1'b0;
        ov_next          = ov_reg && res_stall;
        om_next          = om_reg;
        of_next          = of_reg;
        os_next          = os_reg;
        od_next          = od_reg;
        oc_next          = oc_reg;
        oo_next          = oo_reg;
        ol_next          = ol_reg;

        unique case (state_reg)
            gppm_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        gppm_pkg::OP_LOAD_FIRST:
                        begin
                            cmd_take = 1'b1;
                            if (first_cnt_reg < CB'(gppm_pkg::MaxPeaks))
                                first_cnt_next = first_cnt_reg + 1'b1;
                            else
                                dropped_next = 1'b1;
                        end
                        gppm_pkg::OP_LOAD_SECOND:
                        begin
                            cmd_take = 1'b1;
                            if (second_cnt_reg < CB'(gppm_pkg::MaxPeaks))
                                second_cnt_next = second_cnt_reg + 1'b1;
                            else
                                dropped_next = 1'b1;
                        end
                        gppm_pkg::OP_RUN:
                        begin
                            cmd_take         = 1'b1;
                            first_used_next  = '0;
                            second_used_next = '0;
                            nmatch_next      = '0;
                            pend_next        = 1'b0;
                            i_next           = '0;
                            j_next           = '0;
                            found_next       = 1'b0;
                            state_next       = gppm_pkg::ST_PRE;
                        end
                        default:
                        begin
                            cmd_take = 1'b1;
                        end
                    endcase
                end
            end
            gppm_pkg::ST_PRE:
            begin
                // end of a round scan
                if (i_reg >= first_cnt_reg || second_cnt_reg == '0)
                begin
                    state_next = gppm_pkg::ST_DECIDE;
                end
                else if (!pair_ok)
                begin
                    if (j_reg + 1'b1 >= second_cnt_reg)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
                else
                begin
                    step_next  = '0;
                    state_next = gppm_pkg::ST_DIST;
                end
            end
            gppm_pkg::ST_DIST:
            begin
                // memory read, diff, square, weight stages
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd3)
                    state_next = gppm_pkg::ST_SUM;
            end
            gppm_pkg::ST_SUM:
            begin
                if (!found_reg || dist_sat < best_reg)
                begin
                    found_next = 1'b1;
                    best_next  = dist_sat;
                    bi_next    = i_reg[IB-1:0];
                    bj_next    = j_reg[IB-1:0];
                end
                if (j_reg + 1'b1 >= second_cnt_reg)
                begin
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                end
                else
                    j_next = j_reg + 1'b1;
                state_next = gppm_pkg::ST_PRE;
            end
            gppm_pkg::ST_DECIDE:
            begin
                if (found_reg && best_reg < threshold_sq)
                begin
                    // previous match held back so the last one carries totals
                    if (!pend_reg || out_free)
                    begin
                        if (pend_reg)
                        begin
                            ov_next = 1'b1;
                            om_next = 1'b1;
                            of_next = pf_reg;
                            os_next = ps_reg;
                            od_next = pd_reg;
                            oc_next = '0;
                            oo_next = 1'b0;
                            ol_next = 1'b0;
                        end
                        pf_next = bi_reg;
                        ps_next = bj_reg;
                        pd_next = best_reg;
                        first_used_next[bi_reg]  = 1'b1;
                        second_used_next[bj_reg] = 1'b1;
                        nmatch_next = nmatch_reg + 1'b1;
                        pend_next   = 1'b1;
                        found_next  = 1'b0;
                        i_next      = '0;
                        j_next      = '0;
                        state_next  = gppm_pkg::ST_PRE;
                    end
                end
                else
                begin
                    state_next = gppm_pkg::ST_CLOSE;
                end
            end
            gppm_pkg::ST_CLOSE:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    om_next = pend_reg;
                    of_next = pend_reg ? pf_reg : '0;
                    os_next = pend_reg ? ps_reg : '0;
                    od_next = pend_reg ? pd_reg : '0;
                    oc_next = nmatch_reg;
                    oo_next = dropped_reg;
                    ol_next = 1'b1;
                    first_cnt_next   = '0;
                    second_cnt_next  = '0;
                    first_used_next  = '0;
                    second_used_next = '0;
                    dropped_next     = 1'b0;
                    pend_next        = 1'b0;
                    state_next       = gppm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gppm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/greedy_peak_pair_matcher_core.sv */
// ----------------------------------------------------------------------------
// greedy_peak_pair_matcher_core
// greedy weighted-distance matcher of two 2-D peak sets
// ----------------------------------------------------------------------------
// Loads are taken from the front queue while idle and never produce a result word.
// A run command walks every pair once per greedy round; each pair is skipped if
// either point is used, or otherwise goes through the shared distance pipeline
// (read, difference, square, weight, sum), one pair at a time. Matches leave in
// ascending distance; the final word carries match_count, overflow and last.
// Unknown opcodes are dropped at the front without a result.
module greedy_peak_pair_matcher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] coord_c,
    input  logic [15:0] coord_h,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [48:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        matched,
    output logic [4:0]  first_index,
    output logic [4:0]  second_index,
    output logic [48:0] distance_sq,
    output logic [5:0]  match_count,
    output logic        overflow,
    output logic        last
);

    logic           cmd_valid;
    logic           cmd_take;
    gppm_pkg::cmd_t cmd;
    logic [15:0]    carbon_wt_reg;
    logic [15:0]    proton_wt_reg;
    logic [48:0]    threshold_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carbon_wt_reg <= 16'd4096;
            proton_wt_reg <= 16'd4096;
            threshold_reg <= gppm_pkg::DistMax;
        end
        else if (cfg_we)
        begin
            case (gppm_pkg::reg_index_t'(cfg_index))
                gppm_pkg::REG_WEIGHT_C:  carbon_wt_reg <= cfg_data[15:0];
                gppm_pkg::REG_WEIGHT_H:  proton_wt_reg <= cfg_data[15:0];
                gppm_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    gppm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .coord_c   (coord_c),
        .coord_h   (coord_h),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    gppm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take),
        .carbon_wt    (carbon_wt_reg),
        .proton_wt    (proton_wt_reg),
        .threshold_sq (threshold_reg),
        .res_valid    (out_valid),
        .res_stall    (out_stall),
        .res_matched  (matched),
        .res_first    (first_index),
        .res_second   (second_index),
        .res_dist     (distance_sq),
        .res_count    (match_count),
        .res_overflow (overflow),
        .res_last     (last)
    );

    // a word that is not last must report a match
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> matched)
        else $error("non-last word without match");

    // a non-last word carries no totals
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> match_count == 6'd0 && !overflow)
        else $error("totals on non-last word");

    // an empty close reports zero matches
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && !matched |-> match_count == 6'd0)
        else $error("empty close with count");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the greedy peak pair matcher: loads random point
// sets, runs the greedy walk, and compares every result word against an
// in-bench prediction of the matching
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // one expected result word
    typedef struct {
        logic        matched;
        logic [4:0]  first_index;
        logic [4:0]  second_index;
        logic [48:0] distance_sq;
        logic [5:0]  match_count;
        logic        overflow;
        logic        last;
    } match_word_t;

    // scoreboard: keeps its own copy of the point sets and registers
    class match_scoreboard;
        logic [15:0] wc, wh;
        logic [48:0] thr;
        logic [15:0] fc [gppm_pkg::MaxPeaks], fh [gppm_pkg::MaxPeaks];
        logic [15:0] sc [gppm_pkg::MaxPeaks], sh [gppm_pkg::MaxPeaks];
        int          n_first, n_second;
        bit          dropped;
        match_word_t pending [$];
        int          errors, runs, words;

        function void init();
            wc = 16'd4096;
            wh = 16'd4096;
            thr = gppm_pkg::DistMax;
            n_first = 0;
            n_second = 0;
            dropped = 0;
        endfunction

        function void set_reg(gppm_pkg::reg_index_t idx, logic [48:0] v);
            case (idx)
                gppm_pkg::REG_WEIGHT_C:  wc = v[15:0];
                gppm_pkg::REG_WEIGHT_H:  wh = v[15:0];
                gppm_pkg::REG_THRESHOLD: thr = v;
                default: ;
            endcase
        endfunction

        function logic [48:0] pair_dist(int i, int j);
            logic [63:0] dc, dh, a, b;
            logic [64:0] s;
            dc = (fc[i] > sc[j]) ? fc[i] - sc[j] : sc[j] - fc[i];
            dh = (fh[i] > sh[j]) ? fh[i] - sh[j] : sh[j] - fh[i];
            a = dc * dc * wc;
            b = dh * dh * wh;
            s = {1'b0, a} + {1'b0, b};
            if (s > {16'd0, gppm_pkg::DistMax})
                return gppm_pkg::DistMax;
            return s[48:0];
        endfunction

        // note an accepted input word and predict its results
        function void note_input(gppm_pkg::opcode_t op, logic [15:0] c, logic [15:0] h);
            bit          fu [gppm_pkg::MaxPeaks], su [gppm_pkg::MaxPeaks], found;
            logic [48:0] best, d;
            int          bi, bj, n;
            match_word_t w;
            if (op == gppm_pkg::OP_LOAD_FIRST || op == gppm_pkg::OP_LOAD_SECOND)
            begin
                if (op == gppm_pkg::OP_LOAD_FIRST && n_first < gppm_pkg::MaxPeaks)
                begin
                    fc[n_first] = c;
                    fh[n_first] = h;
                    n_first++;
                end
                else if (op == gppm_pkg::OP_LOAD_SECOND && n_second < gppm_pkg::MaxPeaks)
                begin
                    sc[n_second] = c;
                    sh[n_second] = h;
                    n_second++;
                end
                else
                    dropped = 1;
                return;
            end
            if (op != gppm_pkg::OP_RUN)
                return;
            runs++;
            foreach (fu[k])
            begin
                fu[k] = 0;
                su[k] = 0;
            end
            n = 0;
            forever
            begin
                found = 0;
                best = 0;
                bi = 0;
                bj = 0;
                for (int i = 0; i < n_first; i++)
                begin
                    if (fu[i]) continue;
                    for (int j = 0; j < n_second; j++)
                    begin
                        if (su[j]) continue;
                        d = pair_dist(i, j);
                        if (!found || d < best)
                        begin
                            found = 1;
                            best = d;
                            bi = i;
                            bj = j;
                        end
                    end
                end
                if (!found || best >= thr) break;
                fu[bi] = 1;
                su[bj] = 1;
                w = '{1'b1, bi[4:0], bj[4:0], best, 6'd0, 1'b0, 1'b0};
                pending = {pending, w};
                n++;
            end
            if (n == 0)
            begin
                w = '{1'b0, 5'd0, 5'd0, 49'd0, 6'd0, dropped, 1'b1};
                pending = {pending, w};
            end
            else
            begin
                // closing fields ride on the last match
                pending[$].match_count = n[5:0];
                pending[$].overflow = dropped;
                pending[$].last = 1'b1;
            end
            n_first = 0;
            n_second = 0;
            dropped = 0;
        endfunction

        // compare one accepted result word with the oldest prediction
        function void check_word(match_word_t got);
            match_word_t e;
            words++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word, actual m=%0b i=%0d j=%0d d=%0h", $time,
                         got.matched, got.first_index, got.second_index, got.distance_sq);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.matched !== e.matched)
                report("matched", e.matched, got.matched);
            if (got.first_index !== e.first_index)
                report("first_index", e.first_index, got.first_index);
            if (got.second_index !== e.second_index)
                report("second_index", e.second_index, got.second_index);
            if (got.distance_sq !== e.distance_sq)
                report("distance_sq", e.distance_sq, got.distance_sq);
            if (got.match_count !== e.match_count)
                report("match_count", e.match_count, got.match_count);
            if (got.overflow !== e.overflow)
                report("overflow", e.overflow, got.overflow);
            if (got.last !== e.last)
                report("last", e.last, got.last);
        endfunction

        function void report(string f, logic [48:0] e, logic [48:0] a);
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, f, e, a);
            errors++;
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, in_stall;
    logic [1:0]  opcode;
    logic [15:0] coord_c, coord_h;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [48:0] cfg_data;
    logic        out_valid, out_stall;
    logic        matched, overflow, last;
    logic [4:0]  first_index, second_index;
    logic [48:0] distance_sq;
    logic [5:0]  match_count;

    match_scoreboard sb;
    longint          cycles;
    int              n_items;

    greedy_peak_pair_matcher_core dut (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // watchdog: fails the bench once the cycle counter passes its limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd8000000)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // random gap length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one input word and wait for its handshake; valid stays up
    // between back-to-back words and drops only in a gap or in drain
    task automatic send_word(gppm_pkg::opcode_t op, logic [15:0] c, logic [15:0] h);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        coord_c <= c;
        coord_h <= h;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(op, c, h);
        if (op != gppm_pkg::OP_NONE) n_items++;
        @(negedge clk);
    endtask

    // register write while the block is idle
    task automatic write_reg(gppm_pkg::reg_index_t idx, logic [48:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until all predicted words have arrived, then a short settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // small clustered coordinates so threshold decisions are meaningful
    function automatic logic [15:0] near(logic [15:0] base);
        return base + 16'($urandom_range(0, 600)) - 16'd300;
    endfunction

    // one random set pair followed by a run
    task automatic random_set(int max_n);
        int          nf, ns, r;
        logic [15:0] bc, bh;
        nf = $urandom_range(0, max_n);
        ns = $urandom_range(0, max_n);
        bc = 16'($urandom);
        bh = 16'($urandom);
        for (int k = 0; k < nf + ns; k++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                send_word(gppm_pkg::OP_NONE, 16'($urandom), 16'($urandom));
            else if (r < 4)
                send_word(gppm_pkg::opcode_t'($urandom_range(0, 1)), 16'($urandom),
                          16'($urandom));
            else
                send_word(k < nf ? gppm_pkg::OP_LOAD_FIRST : gppm_pkg::OP_LOAD_SECOND,
                          near(bc), near(bh));
        end
        send_word(gppm_pkg::OP_RUN, 16'($urandom), 16'($urandom));
    endtask

    // result side: random stall, sample at the rising edge
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 25);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word('{matched, first_index, second_index, distance_sq,
                            match_count, overflow, last});
    end

    initial
    begin
        sb = new();
        sb.init();
        cycles = 0;
        n_items = 0;
        rst_n = 0;
        in_valid = 0;
        opcode = gppm_pkg::OP_NONE;
        coord_c = 0;
        coord_h = 0;
        cfg_we = 0;
        cfg_index = gppm_pkg::REG_WEIGHT_C;
        cfg_data = 0;
        repeat (4) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: empty run, unknown opcode, extreme coordinates, tie
        send_word(gppm_pkg::OP_RUN, 16'hffff, 16'h0000);
        send_word(gppm_pkg::OP_NONE, 16'hffff, 16'hffff);
        send_word(gppm_pkg::OP_LOAD_FIRST, 16'h0000, 16'h0000);
        send_word(gppm_pkg::OP_LOAD_FIRST, 16'hffff, 16'hffff);
        send_word(gppm_pkg::OP_LOAD_SECOND, 16'hffff, 16'h0000);
        send_word(gppm_pkg::OP_LOAD_SECOND, 16'h0000, 16'hffff);
        send_word(gppm_pkg::OP_RUN, 16'h0, 16'h0);
        // one set empty
        send_word(gppm_pkg::OP_LOAD_FIRST, 16'h1234, 16'h5678);
        send_word(gppm_pkg::OP_RUN, 16'h0, 16'h0);
        drain();

        // maximum weights and coordinates give the largest sum, which stays below saturation
        write_reg(gppm_pkg::REG_WEIGHT_C, 49'hffff);
        write_reg(gppm_pkg::REG_WEIGHT_H, 49'hffff);
        send_word(gppm_pkg::OP_LOAD_FIRST, 16'h0000, 16'h0000);
        send_word(gppm_pkg::OP_LOAD_SECOND, 16'hffff, 16'hffff);
        send_word(gppm_pkg::OP_RUN, 16'h0, 16'h0);
        drain();

        // zero threshold: nothing matches; zero weights: all distances tie
        write_reg(gppm_pkg::REG_THRESHOLD, 49'd0);
        send_word(gppm_pkg::OP_LOAD_FIRST, 16'h0100, 16'h0100);
        send_word(gppm_pkg::OP_LOAD_SECOND, 16'h0100, 16'h0100);
        send_word(gppm_pkg::OP_RUN, 16'h0, 16'h0);
        drain();
        write_reg(gppm_pkg::REG_WEIGHT_C, 49'd0);
        write_reg(gppm_pkg::REG_WEIGHT_H, 49'd0);
        write_reg(gppm_pkg::REG_THRESHOLD, 49'd1);
        send_word(gppm_pkg::OP_LOAD_FIRST, 16'h0001, 16'h0002);
        send_word(gppm_pkg::OP_LOAD_FIRST, 16'h0003, 16'h0004);
        send_word(gppm_pkg::OP_LOAD_SECOND, 16'h0005, 16'h0006);
        send_word(gppm_pkg::OP_LOAD_SECOND, 16'h0007, 16'h0008);
        send_word(gppm_pkg::OP_RUN, 16'h0, 16'h0);
        drain();

        // full set plus drops, small weights, 33 loads into the first set
        write_reg(gppm_pkg::REG_WEIGHT_C, 49'd4096);
        write_reg(gppm_pkg::REG_WEIGHT_H, 49'd4096);
        write_reg(gppm_pkg::REG_THRESHOLD, gppm_pkg::DistMax);
        for (int k = 0; k < 33; k++)
            send_word(gppm_pkg::OP_LOAD_FIRST, 16'($urandom), 16'($urandom));
        send_word(gppm_pkg::OP_LOAD_SECOND, 16'($urandom), 16'($urandom));
        send_word(gppm_pkg::OP_RUN, 16'h0, 16'h0);
        drain();

        // random phases over several register settings
        for (int p = 0; p < 4; p++)
        begin
            write_reg(gppm_pkg::REG_WEIGHT_C, 49'($urandom_range(0, 65535)));
            write_reg(gppm_pkg::REG_WEIGHT_H, 49'($urandom_range(0, 65535)));
            write_reg(gppm_pkg::REG_THRESHOLD,
                      p[0] ? gppm_pkg::DistMax : {17'($urandom), 32'($urandom)} >> 6);
            while (n_items < 45 + 38 * (p + 1))
                random_set(p == 3 ? 12 : 6);
            drain();
        end

        $display("covered %0d input words, %0d runs and %0d result words", n_items,
                 sb.runs, sb.words);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

/* files.f */
hdl/gppm_pkg.sv
hdl/gppm_front.sv
hdl/gppm_back.sv
hdl/greedy_peak_pair_matcher_core.sv
test/tb_top.sv
